[rtl/core/lma_pkg.sv]
// Shared types, sizes and helper functions for the lumped mass accumulator.
// Used by the accumulator RTL; no other dependencies.

package lma_pkg;

  // Store geometry and field widths
  localparam int NUM_POINTS = 4096;
  localparam int PIDX_W     = $clog2(NUM_POINTS);
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int CROSS_W    = 2 * DIFF_W + 1;
  localparam int MASS_W     = 63;
  localparam int DENS_W     = 32;
  localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};
  localparam logic [DENS_W-1:0] DENSITY_RESET = 32'h0001_0000;

  // Multiply-accumulate datapath: operand A times one 16-bit digit of B
  localparam int ACC_W  = 112;
  localparam int MAG_W  = 80;
  localparam int BMAG_W = 64;
  localparam int DIG_W  = 16;
  localparam int PROD_W = MAG_W + DIG_W;

  // Square root and divide-by-three units
  localparam int RAD_W  = 2 * CROSS_W;
  localparam int ROOT_W = CROSS_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int DIVD_W = 80;
  localparam int DIV_STEPS = DIVD_W / 8;

  // Function codes of an input item; the last code is unused and does nothing
  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_ELEM = 2'd1;
  localparam logic [1:0] FN_READ = 2'd2;
  localparam logic [1:0] FN_NOP  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_DENSITY = 1'b0;
  localparam logic CFG_TET     = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_CROSS,
    S_SQ,
    S_SQRT,
    S_TRIP,
    S_SCALE,
    S_DIV,
    S_MASS_RD,
    S_MASS_WR,
    S_RD_RD,
    S_RD_WR
  } state_t;

  // True when a point index addresses an existing store entry
  function automatic logic idx_ok(input logic [PIDX_W-1:0] i);
    return {1'b0, i} < (PIDX_W + 1)'(NUM_POINTS);
  endfunction

  // Long division of one byte by three; returns {remainder, quotient byte}
  function automatic logic [9:0] div3_byte(input logic [1:0] rin, input logic [7:0] b);
    logic [2:0] r;
    logic [7:0] q;
    r = {1'b0, rin};
    q = '0;
    for (int k = 7; k >= 0; k--) begin
      r = {r[1:0], b[k]};
      if (r >= 3'd3) begin
        r = r - 3'd3;
        q[k] = 1'b1;
      end
    end
    return {r[1:0], q};
  endfunction

endpackage

[rtl/core/lma_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module lma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/lumped_mass_accumulator.sv]
// Lumped mass accumulator top level: coordinate stores, mass store, shared MAC,
// square root and divide-by-three sequencer. Depends on lma_pkg and lma_ram.
//
//   channel   signals                                   transfer
//   --------  ----------------------------------------  ------------------------
//   command   start, busy, func, point_index, pos_*,    start high, busy low
//             vertex_a .. vertex_d
//   result    done, mass_value, clipped                 done high, one cycle
//   config    cfg_wr, cfg_addr, cfg_data                cfg_wr high
//
// Load is written when accepted; read-and-clear passes S_RD_RD and S_RD_WR, and its result
// appears in the same cycle as busy drops. A triangle is dominated by the 51-step bitwise
// square root. Both kinds run vertex fetch, cross product, norm (triangle) or triple product
// (tetrahedron), density scale, divide by three and a mass read-modify-write per vertex on the
// single mass store. After reset, busy stays high while the mass store is cleared.
// Results cannot be held off; only one item is in flight.

module lumped_mass_accumulator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          func,
  input  logic [lma_pkg::PIDX_W-1:0]          point_index,
  input  logic signed [lma_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [lma_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [lma_pkg::COORD_W-1:0]  pos_z,
  input  logic [lma_pkg::PIDX_W-1:0]          vertex_a,
  input  logic [lma_pkg::PIDX_W-1:0]          vertex_b,
  input  logic [lma_pkg::PIDX_W-1:0]          vertex_c,
  input  logic [lma_pkg::PIDX_W-1:0]          vertex_d,
  input  logic                                cfg_wr,
  input  logic                                cfg_addr,
  input  logic [lma_pkg::DENS_W-1:0]          cfg_data,
  output logic                                done,
  output logic [lma_pkg::MASS_W-1:0]          mass_value,
  output logic                                clipped
);

  lma_pkg::state_t state, state_next;

  logic [lma_pkg::DENS_W-1:0] density;
  logic                       tet_mode;

  logic [lma_pkg::PIDX_W-1:0] vtx [4];
  logic [lma_pkg::PIDX_W-1:0] pidx;
  logic                       rd_ok;
  logic [lma_pkg::PIDX_W-1:0] clr_cnt;
  logic [2:0]                 fcnt;
  logic [1:0]                 mcnt;
  logic [2:0]                 nvert;

  logic signed [lma_pkg::COORD_W-1:0] pa_x, pa_y, pa_z;
  logic signed [lma_pkg::DIFF_W-1:0]  dx [3];
  logic signed [lma_pkg::DIFF_W-1:0]  dy [3];
  logic signed [lma_pkg::DIFF_W-1:0]  dz [3];
  logic signed [lma_pkg::CROSS_W-1:0] crs [3];

  logic [2:0] term;
  logic [1:0] dig;
  logic signed [lma_pkg::ACC_W-1:0] acc, acc_next;
  logic [lma_pkg::MAG_W-1:0] scale_a;

  logic [lma_pkg::RAD_W-1:0]  rad;
  logic [lma_pkg::ROOT_W-1:0] root, root_next;
  logic [lma_pkg::REM_W-1:0]  rem, rem_next;
  logic [5:0]                 sq_cnt;

  logic [lma_pkg::DIVD_W-1:0] divd, quo;
  logic [1:0]                 drem;
  logic [3:0]                 dv_cnt;
  logic [9:0]                 dstep;
  logic [lma_pkg::MASS_W-1:0] share;

  logic accept, elem_ok;

  // Memory ports
  logic                                coord_we;
  logic [lma_pkg::PIDX_W-1:0]          coord_raddr;
  logic [lma_pkg::COORD_W-1:0]         rx, ry, rz;
  logic                                mass_we;
  logic [lma_pkg::PIDX_W-1:0]          mass_waddr, mass_raddr;
  logic [lma_pkg::MASS_W-1:0]          mass_wdata, mass_rdata, mass_sum;
  logic [lma_pkg::MASS_W:0]            mass_add;
  logic [lma_pkg::MASS_W-1:0]          rd_val;

  assign busy   = (state != lma_pkg::S_IDLE);
  assign accept = start && !busy;
  assign nvert  = tet_mode ? 3'd4 : 3'd3;

  assign elem_ok = lma_pkg::idx_ok(vertex_a) && lma_pkg::idx_ok(vertex_b) &&
                   lma_pkg::idx_ok(vertex_c) && (!tet_mode || lma_pkg::idx_ok(vertex_d));

  // Coordinate and mass stores
  lma_ram #(.WIDTH(lma_pkg::COORD_W), .DEPTH(lma_pkg::NUM_POINTS)) u_x_ram (
    .clk(clk), .we(coord_we), .waddr(point_index), .wdata(pos_x),
    .raddr(coord_raddr), .rdata(rx)
  );
  lma_ram #(.WIDTH(lma_pkg::COORD_W), .DEPTH(lma_pkg::NUM_POINTS)) u_y_ram (
    .clk(clk), .we(coord_we), .waddr(point_index), .wdata(pos_y),
    .raddr(coord_raddr), .rdata(ry)
  );
  lma_ram #(.WIDTH(lma_pkg::COORD_W), .DEPTH(lma_pkg::NUM_POINTS)) u_z_ram (
    .clk(clk), .we(coord_we), .waddr(point_index), .wdata(pos_z),
    .raddr(coord_raddr), .rdata(rz)
  );
  lma_ram #(.WIDTH(lma_pkg::MASS_W), .DEPTH(lma_pkg::NUM_POINTS)) u_mass_ram (
    .clk(clk), .we(mass_we), .waddr(mass_waddr), .wdata(mass_wdata),
    .raddr(mass_raddr), .rdata(mass_rdata)
  );

  // MAC operand select
  logic signed [lma_pkg::MAG_W-1:0]  mac_a;
  logic signed [lma_pkg::BMAG_W-1:0] mac_b;
  logic                              mac_sub;
  logic [lma_pkg::MAG_W-1:0]         a_mag;
  logic [lma_pkg::BMAG_W-1:0]        b_mag;
  logic                              mac_neg;
  logic [lma_pkg::PROD_W-1:0]        prod;
  logic [lma_pkg::ACC_W-1:0]         shifted;
  logic                              last_dig, last_term;

  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_sub = 1'b0;
    case (state)
      lma_pkg::S_CROSS: begin
        case (term)
          3'd0: begin mac_a = lma_pkg::MAG_W'(dy[0]); mac_b = lma_pkg::BMAG_W'(dz[1]); end
          3'd1: begin
            mac_a = lma_pkg::MAG_W'(dz[0]); mac_b = lma_pkg::BMAG_W'(dy[1]); mac_sub = 1'b1;
          end
          3'd2: begin mac_a = lma_pkg::MAG_W'(dz[0]); mac_b = lma_pkg::BMAG_W'(dx[1]); end
          3'd3: begin
            mac_a = lma_pkg::MAG_W'(dx[0]); mac_b = lma_pkg::BMAG_W'(dz[1]); mac_sub = 1'b1;
          end
          3'd4: begin mac_a = lma_pkg::MAG_W'(dx[0]); mac_b = lma_pkg::BMAG_W'(dy[1]); end
          default: begin
            mac_a = lma_pkg::MAG_W'(dy[0]); mac_b = lma_pkg::BMAG_W'(dx[1]); mac_sub = 1'b1;
          end
        endcase
      end
      lma_pkg::S_SQ: begin
        mac_a = lma_pkg::MAG_W'(crs[term[1:0]]);
        mac_b = lma_pkg::BMAG_W'(crs[term[1:0]]);
      end
      lma_pkg::S_TRIP: begin
        mac_a = lma_pkg::MAG_W'(crs[term[1:0]]);
        case (term)
          3'd0:    mac_b = lma_pkg::BMAG_W'(dx[2]);
          3'd1:    mac_b = lma_pkg::BMAG_W'(dy[2]);
          default: mac_b = lma_pkg::BMAG_W'(dz[2]);
        endcase
      end
      lma_pkg::S_SCALE: begin
        mac_a = signed'(scale_a);
        mac_b = signed'({{(lma_pkg::BMAG_W - lma_pkg::DENS_W){1'b0}}, density});
      end
      default: ;
    endcase
  end

  // Multiply one digit and accumulate, signed through magnitudes
  always_comb begin
    a_mag    = mac_a[lma_pkg::MAG_W-1] ? lma_pkg::MAG_W'(-mac_a) : mac_a;
    b_mag    = mac_b[lma_pkg::BMAG_W-1] ? lma_pkg::BMAG_W'(-mac_b) : mac_b;
    mac_neg  = mac_a[lma_pkg::MAG_W-1] ^ mac_b[lma_pkg::BMAG_W-1] ^ mac_sub;
    prod     = a_mag * b_mag[dig*lma_pkg::DIG_W +: lma_pkg::DIG_W];
    shifted  = lma_pkg::ACC_W'(prod) << {dig, 4'b0000};
    acc_next = mac_neg ? acc - signed'(shifted) : acc + signed'(shifted);
    last_dig = (state == lma_pkg::S_SQ) ? (dig == 2'd3) : (dig == 2'd1);
    case (state)
      lma_pkg::S_CROSS: last_term = (term == 3'd5);
      lma_pkg::S_SCALE: last_term = (term == 3'd0);
      default:          last_term = (term == 3'd2);
    endcase
  end

  // Bitwise square root step
  logic [lma_pkg::REM_W+1:0] rem_sh, trial;
  logic                      sq_ge;
  always_comb begin
    rem_sh    = {rem, rad[lma_pkg::RAD_W-1 -: 2]};
    trial     = (lma_pkg::REM_W + 2)'({root, 2'b01});
    sq_ge     = (rem_sh >= trial);
    rem_next  = sq_ge ? lma_pkg::REM_W'(rem_sh - trial) : lma_pkg::REM_W'(rem_sh);
    root_next = {root[lma_pkg::ROOT_W-2:0], sq_ge};
  end

  // Divide step, share saturation, saturating mass add, read value select and absolute MAC sum
  logic signed [lma_pkg::ACC_W-1:0] t_abs;
  always_comb begin
    dstep    = lma_pkg::div3_byte(drem, divd[lma_pkg::DIVD_W-1 -: 8]);
    share    = (quo[lma_pkg::DIVD_W-1:lma_pkg::MASS_W] != '0) ? lma_pkg::MASS_MAX
                                                              : quo[lma_pkg::MASS_W-1:0];
    mass_add = {1'b0, mass_rdata} + {1'b0, share};
    mass_sum = mass_add[lma_pkg::MASS_W] ? lma_pkg::MASS_MAX : mass_add[lma_pkg::MASS_W-1:0];
    rd_val   = rd_ok ? mass_rdata : '0;
    t_abs    = acc_next[lma_pkg::ACC_W-1] ? -acc_next : acc_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lma_pkg::S_CLEAR:
        if (clr_cnt == lma_pkg::PIDX_W'(lma_pkg::NUM_POINTS - 1)) state_next = lma_pkg::S_IDLE;
      lma_pkg::S_IDLE:
        if (accept) begin
          case (func)
            lma_pkg::FN_ELEM: if (elem_ok) state_next = lma_pkg::S_FETCH;
            lma_pkg::FN_READ: state_next = lma_pkg::S_RD_RD;
            default: ;
          endcase
        end
      lma_pkg::S_FETCH:
        if (fcnt == nvert) state_next = lma_pkg::S_CROSS;
      lma_pkg::S_CROSS:
        if (last_dig && last_term) state_next = tet_mode ? lma_pkg::S_TRIP : lma_pkg::S_SQ;
      lma_pkg::S_SQ:
        if (last_dig && last_term) state_next = lma_pkg::S_SQRT;
      lma_pkg::S_SQRT:
        if (sq_cnt == 6'(lma_pkg::ROOT_W - 1)) state_next = lma_pkg::S_SCALE;
      lma_pkg::S_TRIP:
        if (last_dig && last_term) state_next = lma_pkg::S_SCALE;
      lma_pkg::S_SCALE:
        if (last_dig) state_next = lma_pkg::S_DIV;
      lma_pkg::S_DIV:
        if (dv_cnt == 4'(lma_pkg::DIV_STEPS - 1)) state_next = lma_pkg::S_MASS_RD;
      lma_pkg::S_MASS_RD:
        state_next = lma_pkg::S_MASS_WR;
      lma_pkg::S_MASS_WR:
        state_next = ({1'b0, mcnt} == nvert - 3'd1) ? lma_pkg::S_IDLE : lma_pkg::S_MASS_RD;
      lma_pkg::S_RD_RD:
        state_next = lma_pkg::S_RD_WR;
      lma_pkg::S_RD_WR:
        state_next = lma_pkg::S_IDLE;
      default:
        state_next = lma_pkg::S_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    coord_we    = accept && (func == lma_pkg::FN_LOAD) && lma_pkg::idx_ok(point_index);
    coord_raddr = vtx[fcnt[1:0]];
    mass_we     = 1'b0;
    mass_waddr  = pidx;
    mass_wdata  = '0;
    mass_raddr  = (state == lma_pkg::S_MASS_RD) ? vtx[mcnt] : pidx;
    unique case (state)
      lma_pkg::S_CLEAR: begin
        mass_we    = 1'b1;
        mass_waddr = clr_cnt;
      end
      lma_pkg::S_MASS_WR: begin
        mass_we    = 1'b1;
        mass_waddr = vtx[mcnt];
        mass_wdata = mass_sum;
      end
      lma_pkg::S_RD_WR: mass_we = rd_ok;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lma_pkg::S_CLEAR;
      density  <= lma_pkg::DENSITY_RESET;
      tet_mode <= 1'b0;
      clr_cnt  <= '0;
      fcnt     <= '0;
      mcnt     <= '0;
      term     <= '0;
      dig      <= '0;
      sq_cnt   <= '0;
      dv_cnt   <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == lma_pkg::S_RD_WR);
      if (cfg_wr) begin
        unique case (cfg_addr)
          lma_pkg::CFG_DENSITY: density <= cfg_data;
          lma_pkg::CFG_TET:     tet_mode <= cfg_data[0];
        endcase
      end
      if (state == lma_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      // advance digit and term counters of the MAC
      if (state == lma_pkg::S_CROSS || state == lma_pkg::S_SQ ||
          state == lma_pkg::S_TRIP || state == lma_pkg::S_SCALE) begin
        if (last_dig) begin
          dig  <= '0;
          term <= last_term ? 3'd0 : term + 3'd1;
        end else begin
          dig <= dig + 2'd1;
        end
      end
      fcnt   <= (state == lma_pkg::S_FETCH) ? fcnt + 3'd1 : 3'd0;
      sq_cnt <= (state == lma_pkg::S_SQRT) ? sq_cnt + 6'd1 : 6'd0;
      dv_cnt <= (state == lma_pkg::S_DIV) ? dv_cnt + 4'd1 : 4'd0;
      if (state == lma_pkg::S_IDLE) mcnt <= '0;
      else if (state == lma_pkg::S_MASS_WR) mcnt <= mcnt + 2'd1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      vtx[0] <= vertex_a;
      vtx[1] <= vertex_b;
      vtx[2] <= vertex_c;
      vtx[3] <= vertex_d;
      pidx   <= point_index;
      rd_ok  <= lma_pkg::idx_ok(point_index);
      acc    <= '0;
    end
    // capture fetched positions as differences to the first vertex
    if (state == lma_pkg::S_FETCH && fcnt != 3'd0) begin
      if (fcnt == 3'd1) begin
        pa_x <= signed'(rx);
        pa_y <= signed'(ry);
        pa_z <= signed'(rz);
      end else begin
        dx[fcnt[1:0] - 2'd2] <= lma_pkg::DIFF_W'(signed'(rx)) - lma_pkg::DIFF_W'(pa_x);
        dy[fcnt[1:0] - 2'd2] <= lma_pkg::DIFF_W'(signed'(ry)) - lma_pkg::DIFF_W'(pa_y);
        dz[fcnt[1:0] - 2'd2] <= lma_pkg::DIFF_W'(signed'(rz)) - lma_pkg::DIFF_W'(pa_z);
      end
    end
    unique case (state)
      lma_pkg::S_CROSS: begin
        if (last_dig && term[0]) begin
          crs[term[2:1]] <= acc_next[lma_pkg::CROSS_W-1:0];
          acc            <= '0;
        end else begin
          acc <= acc_next;
        end
      end
      lma_pkg::S_SQ: begin
        acc <= acc_next;
        if (last_dig && last_term) begin
          rad  <= acc_next[lma_pkg::RAD_W-1:0];
          root <= '0;
          rem  <= '0;
        end
      end
      lma_pkg::S_SQRT: begin
        rad  <= rad << 2;
        root <= root_next;
        rem  <= rem_next;
        scale_a <= lma_pkg::MAG_W'(root_next);
        acc  <= '0;
      end
      lma_pkg::S_TRIP: begin
        acc <= acc_next;
        if (last_dig && last_term) begin
          scale_a <= t_abs[lma_pkg::MAG_W-1:0];
          acc     <= '0;
        end
      end
      lma_pkg::S_SCALE: begin
        acc <= acc_next;
        if (last_dig) begin
          // drop the Q16 density fraction, the half and the fixed point scale
          divd <= tet_mode ? acc_next[lma_pkg::DIVD_W+30:31] : acc_next[lma_pkg::DIVD_W+16:17];
          quo  <= '0;
          drem <= '0;
        end
      end
      lma_pkg::S_DIV: begin
        divd <= divd << 8;
        quo  <= {quo[lma_pkg::DIVD_W-9:0], dstep[7:0]};
        drem <= dstep[9:8];
      end
      lma_pkg::S_RD_WR: begin
        mass_value <= rd_val;
        clipped    <= (rd_val == lma_pkg::MASS_MAX);
      end
      default: ;
    endcase
  end

  // Result strobe comes only from a read-and-clear item
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == lma_pkg::S_RD_WR)
    else $error("result strobe without a read item");

  // Every mass write of an element follows its own read
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (state == lma_pkg::S_MASS_WR) |-> $past(state) == lma_pkg::S_MASS_RD)
    else $error("mass write without preceding read");

  // Work starts only from an accepted transfer
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("block went busy without a command");

endmodule
